FILE: rtl/kwst_pkg.sv
// ----------------------------------------------------------------------------
// kwst_pkg: shared constants for the keyed weight sum table
// field widths, default sizes and command codes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kwst_pkg;

    // item field widths
    localparam int KEY_BITS    = 10;
    localparam int WEIGHT_BITS = 10;
    localparam int TOTAL_BITS  = 20;

    // packed stream widths, rounded up to whole bytes
    localparam int IN_DATA_W  = ((KEY_BITS + WEIGHT_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((KEY_BITS + TOTAL_BITS + 7) / 8) * 8;

    // default table geometry
    localparam int DEF_KEY_COUNT = 1024;
    localparam int DEF_SUM_BITS  = 20;

    // presence map row is 2**ROW_BITS keys wide
    localparam int ROW_BITS = 5;

    // command codes
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_POP = 1'b1;

endpackage : kwst_pkg

`default_nettype wire

FILE: rtl/keyed_weight_sum_table_core.sv
// ----------------------------------------------------------------------------
// keyed_weight_sum_table_core: group-by-key weight accumulator
// adds weights into per-key totals and pops keys in ascending order
// ----------------------------------------------------------------------------
// usage
//   input stream (s_*): one command per item, tuser = command
//     add: adds tdata.weight into the total of tdata.key, marks key present,
//          produces no result; keys at or above KEY_COUNT are dropped
//     pop: removes the smallest present key and sends one result item
//   result stream (m_*): key, saturated total, tlast when the table became
//     empty with this pop, tuser flags empty (nothing present) and saturated
//   steps
//     add: table read, then read-modify-write of the entry
//     pop: summary scan and row read, row scan and total read, result
//     load; an empty pop goes straight to the result load
//     the two table rams have a registered read; one item in flight
//     at a time
//   reset: synchronous, active low; the per-row summary bits and the key
//     count clear at once, so the table is empty right away with no sweep
//   stall: a result waiting on m_tready holds its register; adds keep
//     being taken, a pop waits in its last step until the register frees
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyed_weight_sum_table_core import kwst_pkg::*; #(
    parameter int KEY_COUNT = DEF_KEY_COUNT,
    parameter int SUM_BITS  = DEF_SUM_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // key[9:0], weight[19:10], zero pad
    input  wire logic [0:0]            s_tuser,   // command[0]

    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata,   // out_key[9:0], total[29:10], zero pad
    output logic                       m_tlast,   // last
    output logic      [1:0]            m_tuser    // empty_res[0], saturated[1]
);

    // table geometry
    localparam int SUM_ADDR_W = $clog2(KEY_COUNT);
    localparam int KEY_ADDR_W = (SUM_ADDR_W > ROW_BITS) ? SUM_ADDR_W : ROW_BITS + 1;
    localparam int ROW_IDX_W  = KEY_ADDR_W - ROW_BITS;
    localparam int ROWS       = 1 << ROW_IDX_W;
    localparam int ROW_W      = 1 << ROW_BITS;
    localparam int CNT_W      = $clog2(KEY_COUNT + 1);
    localparam int ENTRY_W    = SUM_BITS + 1;
    localparam int ADD_W      = ((SUM_BITS > WEIGHT_BITS) ? SUM_BITS : WEIGHT_BITS) + 1;
    localparam int PAD_W      = OUT_DATA_W - KEY_BITS - TOTAL_BITS;

    // sequencer states
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_ADD_WR  = 2'd1;
    localparam logic [1:0] ST_POP_ROW = 2'd2;
    localparam logic [1:0] ST_POP_OUT = 2'd3;

    // registers
    logic [1:0]             state_reg,     state_next;
    logic [KEY_ADDR_W-1:0]  key_addr_reg,  key_addr_next;
    logic [WEIGHT_BITS-1:0] weight_reg,    weight_next;
    logic                   empty_pop_reg, empty_pop_next;
    logic [ROWS-1:0]        summary_reg,   summary_next;   // row holds a present key
    logic [CNT_W-1:0]       count_reg,     count_next;     // present keys
    logic                   m_tvalid_reg,  m_tvalid_next;
    logic [KEY_BITS-1:0]    out_key_reg,   out_key_next;
    logic [TOTAL_BITS-1:0]  total_reg,     total_next;
    logic                   empty_reg,     empty_next;
    logic                   last_reg,      last_next;
    logic                   sat_reg,       sat_next;

    // input fields
    logic                   in_cmd;
    logic [KEY_BITS-1:0]    in_key;
    logic [WEIGHT_BITS-1:0] in_weight;
    logic                   in_range;
    logic                   in_accept;
    logic                   out_free;

    // ram ports
    logic                   pres_wr_en, pres_rd_en;
    logic [ROW_IDX_W-1:0]   pres_wr_addr, pres_rd_addr;
    logic [ROW_W-1:0]       pres_wr_data, pres_rd_data;
    logic                   sum_wr_en, sum_rd_en;
    logic [SUM_ADDR_W-1:0]  sum_wr_addr, sum_rd_addr;
    logic [ENTRY_W-1:0]     sum_wr_data, sum_rd_data;

    // datapath
    logic [ROW_IDX_W-1:0]   first_row;
    logic [ROW_BITS-1:0]    first_bit;
    logic [ROW_IDX_W-1:0]   cur_row;
    logic [ROW_BITS-1:0]    cur_bit;
    logic [ROW_W-1:0]       row_word;
    logic [ROW_W-1:0]       cur_onehot;
    logic [ROW_W-1:0]       pop_onehot;
    logic                   was_present;
    logic [ENTRY_W-1:0]     old_entry;
    logic [ADD_W-1:0]       sum_wide;
    logic                   sat_hit;
    logic [SUM_BITS-1:0]    new_sum;

    assign in_cmd    = s_tuser[0];
    assign in_key    = s_tdata[KEY_BITS-1:0];
    assign in_weight = s_tdata[KEY_BITS+WEIGHT_BITS-1:KEY_BITS];
    assign in_range  = 32'(in_key) < 32'(KEY_COUNT);

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // lowest non-empty row, then lowest present key inside it
    kwst_ffs #(.W(ROWS)) u_row_ffs (
        .vec (summary_reg),
        .idx (first_row)
    );

    kwst_ffs #(.W(ROW_W)) u_bit_ffs (
        .vec (row_word),
        .idx (first_bit)
    );

    // presence map rows, valid only while their summary bit is set
    kwst_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_pres_ram (
        .aclk    (aclk),
        .wr_en   (pres_wr_en),
        .wr_addr (pres_wr_addr),
        .wr_data (pres_wr_data),
        .rd_en   (pres_rd_en),
        .rd_addr (pres_rd_addr),
        .rd_data (pres_rd_data)
    );

    // totals with sticky saturation bit on top, valid only while present
    kwst_ram #(.WIDTH(ENTRY_W), .DEPTH(KEY_COUNT)) u_sum_ram (
        .aclk    (aclk),
        .wr_en   (sum_wr_en),
        .wr_addr (sum_wr_addr),
        .wr_data (sum_wr_data),
        .rd_en   (sum_rd_en),
        .rd_addr (sum_rd_addr),
        .rd_data (sum_rd_data)
    );

    assign cur_row    = key_addr_reg[KEY_ADDR_W-1:ROW_BITS];
    assign cur_bit    = key_addr_reg[ROW_BITS-1:0];
    assign row_word   = summary_reg[cur_row] ? pres_rd_data : '0;
    assign cur_onehot = ROW_W'(1) << cur_bit;
    assign pop_onehot = ROW_W'(1) << first_bit;

    // add: old total counts only if the key is present
    assign was_present = row_word[cur_bit];
    assign old_entry   = was_present ? sum_rd_data : '0;
    assign sum_wide    = ADD_W'(old_entry[SUM_BITS-1:0]) + ADD_W'(weight_reg);
    assign sat_hit     = sum_wide >= ADD_W'({SUM_BITS{1'b1}});
    assign new_sum     = sat_hit ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];

    always_comb begin
        state_next     = state_reg;
        key_addr_next  = key_addr_reg;
        weight_next    = weight_reg;
        empty_pop_next = empty_pop_reg;
        summary_next   = summary_reg;
        count_next     = count_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_key_next   = out_key_reg;
        total_next     = total_reg;
        empty_next     = empty_reg;
        last_next      = last_reg;
        sat_next       = sat_reg;

        pres_rd_en   = 1'b0;
        pres_rd_addr = ROW_IDX_W'(KEY_ADDR_W'(in_key) >> ROW_BITS);
        pres_wr_en   = 1'b0;
        pres_wr_addr = cur_row;
        pres_wr_data = row_word | cur_onehot;
        sum_rd_en    = 1'b0;
        sum_rd_addr  = SUM_ADDR_W'(in_key);
        sum_wr_en    = 1'b0;
        sum_wr_addr  = SUM_ADDR_W'(key_addr_reg);
        sum_wr_data  = {old_entry[SUM_BITS] | sat_hit, new_sum};

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_cmd == CMD_ADD) begin
                        if (in_range) begin
                            key_addr_next = KEY_ADDR_W'(in_key);
                            weight_next   = in_weight;
                            pres_rd_en    = 1'b1;
                            sum_rd_en     = 1'b1;
                            state_next    = ST_ADD_WR;
                        end
                    end else if (count_reg == '0) begin
                        empty_pop_next = 1'b1;
                        state_next     = ST_POP_OUT;
                    end else begin
                        empty_pop_next = 1'b0;
                        key_addr_next  = {first_row, {ROW_BITS{1'b0}}};
                        pres_rd_addr   = first_row;
                        pres_rd_en     = 1'b1;
                        state_next     = ST_POP_ROW;
                    end
                end
            end
            ST_ADD_WR: begin
                sum_wr_en             = 1'b1;
                pres_wr_en            = 1'b1;
                summary_next[cur_row] = 1'b1;
                if (!was_present) begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = ST_IDLE;
            end
            ST_POP_ROW: begin
                key_addr_next = {cur_row, first_bit};
                sum_rd_addr   = SUM_ADDR_W'({cur_row, first_bit});
                sum_rd_en     = 1'b1;
                pres_wr_en    = 1'b1;
                pres_wr_data  = row_word & ~pop_onehot;
                if ((row_word & ~pop_onehot) == '0) begin
                    summary_next[cur_row] = 1'b0;
                end
                state_next = ST_POP_OUT;
            end
            ST_POP_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (empty_pop_reg) begin
                        out_key_next = '0;
                        total_next   = '0;
                        empty_next   = 1'b1;
                        last_next    = 1'b0;
                        sat_next     = 1'b0;
                    end else begin
                        out_key_next = KEY_BITS'(key_addr_reg);
                        total_next   = TOTAL_BITS'(sum_rd_data[SUM_BITS-1:0]);
                        empty_next   = 1'b0;
                        last_next    = (count_reg == CNT_W'(1));
                        sat_next     = sum_rd_data[SUM_BITS];
                        count_next   = count_reg - CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            summary_reg  <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            summary_reg  <= summary_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        key_addr_reg  <= key_addr_next;
        weight_reg    <= weight_next;
        empty_pop_reg <= empty_pop_next;
        out_key_reg   <= out_key_next;
        total_reg     <= total_next;
        empty_reg     <= empty_next;
        last_reg      <= last_next;
        sat_reg       <= sat_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, total_reg, out_key_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = {sat_reg, empty_reg};

    // between items the key count and the row summary agree on emptiness
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ((count_reg == '0) == (summary_reg == '0)))
        else $error("key count and row summary disagree");

    // an empty pop never carries last or saturated
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && empty_reg) |-> (!last_reg && !sat_reg))
        else $error("empty result with last or saturated set");

    // a new result is only loaded from the pop output step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_POP_OUT))
        else $error("result loaded outside pop output step");

endmodule : keyed_weight_sum_table_core

`default_nettype wire

FILE: rtl/kwst_ram.sv
// ----------------------------------------------------------------------------
// kwst_ram: generic single-write, single-read ram
// one write port, one read port with a registered read, read data holds
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kwst_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : kwst_ram

`default_nettype wire

FILE: rtl/kwst_ffs.sv
// ----------------------------------------------------------------------------
// kwst_ffs: find first set
// index of the lowest set bit of a vector, zero when none is set
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kwst_ffs #(
    parameter int W = 32,
    localparam int IW = (W > 1) ? $clog2(W) : 1
) (
    input  wire logic [W-1:0]  vec,
    output logic      [IW-1:0] idx
);

    always_comb begin
        idx = '0;
        // scan downward so the lowest set bit wins
        for (int i = W - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = IW'(i);
            end
        end
    end

endmodule : kwst_ffs

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: keyed weight sum table core
// streams add and pop commands into the table, predicts every pop result
// from a local copy of the per-key totals, and checks results in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import kwst_pkg::*;

    localparam int          STALL_LIMIT = 5000;
    localparam int          LONG_HOLD   = 400;
    localparam int unsigned TOTAL_CEIL  = (32'd1 << DEF_SUM_BITS) - 1;

    typedef struct packed {
        logic                   cmd;
        logic [KEY_BITS-1:0]    key;
        logic [WEIGHT_BITS-1:0] weight;
        logic                   drain;   // wait for all pop results before going on
    } cmd_item_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   out_key;
        logic [TOTAL_BITS-1:0] total;
        logic                  empty_res;
        logic                  last;
        logic                  saturated;
    } pop_result_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic [1:0]            m_tuser;

    // local copy of the table
    int unsigned key_total   [DEF_KEY_COUNT];
    logic        key_sat     [DEF_KEY_COUNT];
    logic        key_present [DEF_KEY_COUNT];
    int unsigned present_keys;

    cmd_item_t   cmd_queue[$];
    pop_result_t expected_pops[$];
    cmd_item_t   drive_item;

    int unsigned send_gap       = 0;
    int unsigned send_burst     = 0;
    int unsigned recv_hold      = 0;
    int unsigned recv_burst     = 0;
    logic        long_hold_done = 1'b0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;

    keyed_weight_sum_table_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // add saturates at the ceiling, pop takes the smallest present key
    function automatic void predict_table_op(input cmd_item_t it);
        pop_result_t r;
        int unsigned acc;
        logic        found;
        if (it.cmd == CMD_ADD) begin
            acc = key_total[it.key] + it.weight;
            if (acc >= TOTAL_CEIL) begin
                acc = TOTAL_CEIL;
                key_sat[it.key] = 1'b1;
            end
            key_total[it.key] = acc;
            if (!key_present[it.key]) begin
                key_present[it.key] = 1'b1;
                present_keys++;
            end
        end else begin
            r = '0;
            r.empty_res = 1'b1;
            found = 1'b0;
            for (int k = 0; k < DEF_KEY_COUNT && !found; k++) begin
                if (key_present[k]) begin
                    found = 1'b1;
                    present_keys--;
                    r.out_key   = KEY_BITS'(k);
                    r.total     = TOTAL_BITS'(key_total[k]);
                    r.empty_res = 1'b0;
                    r.last      = (present_keys == 0);
                    r.saturated = key_sat[k];
                    key_present[k] = 1'b0;
                    key_total[k]   = 0;
                    key_sat[k]     = 1'b0;
                end
            end
            expected_pops.insert(expected_pops.size(), r);
        end
    endfunction

    function automatic void queue_cmd(input cmd_item_t it);
        cmd_queue.insert(cmd_queue.size(), it);
    endfunction

    function automatic void add_cmd(input logic [KEY_BITS-1:0] k,
                                    input logic [WEIGHT_BITS-1:0] w);
        cmd_item_t it;
        it = '{CMD_ADD, k, w, 1'b0};
        queue_cmd(it);
    endfunction

    // key and weight are don't-care on a pop, so they carry noise
    function automatic void pop_cmd();
        cmd_item_t it;
        it = '{CMD_POP, KEY_BITS'($urandom), WEIGHT_BITS'($urandom), 1'b0};
        queue_cmd(it);
    endfunction

    function automatic void drain_mark();
        cmd_item_t it;
        it = '{CMD_ADD, {KEY_BITS{1'b0}}, {WEIGHT_BITS{1'b0}}, 1'b1};
        queue_cmd(it);
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key(input int unsigned base);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return KEY_BITS'(base + $urandom_range(0, 7));
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] pick_weight();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return WEIGHT_BITS'($urandom);
    endfunction

    // input side: one item in flight on the bus, gaps drawn after each load outside a burst
    always @(posedge aclk) begin : drive_commands
        cmd_item_t            nxt;
        logic                 offer;
        logic [IN_DATA_W-1:0] packed_data;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            offer = s_tvalid && !s_tready;
            if (s_tvalid && s_tready) begin
                predict_table_op(drive_item);
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (cmd_queue.size() != 0) begin
                    if (cmd_queue[0].drain) begin
                        if (expected_pops.size() == 0) void'(cmd_queue.pop_front());
                    end else begin
                        nxt         = cmd_queue.pop_front();
                        drive_item  = nxt;
                        packed_data = '0;
                        packed_data[KEY_BITS-1:0]           = nxt.key;
                        packed_data[KEY_BITS+:WEIGHT_BITS] = nxt.weight;
                        s_tdata <= packed_data;
                        s_tuser <= nxt.cmd;
                        offer = 1'b1;
                        if (send_burst > 0) begin
                            send_burst--;
                        end else begin
                            if ($urandom_range(0, 49) == 0) send_burst = $urandom_range(40, 120);
                            send_gap = draw_gap();
                        end
                    end
                end
            end
            s_tvalid <= offer;
        end
    end

    // result side: check against the oldest prediction, stall at random
    always @(posedge aclk) begin : check_results
        pop_result_t got;
        pop_result_t want;
        logic        rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.out_key   = m_tdata[KEY_BITS-1:0];
                got.total     = m_tdata[KEY_BITS+:TOTAL_BITS];
                got.empty_res = m_tuser[0];
                got.last      = m_tlast;
                got.saturated = m_tuser[1];
                results_seen++;
                if (expected_pops.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: extra key=%0d total=%0d empty=%0b last=%0b sat=%0b",
                                 $realtime, got.out_key, got.total, got.empty_res,
                                 got.last, got.saturated);
                end else begin
                    want = expected_pops.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: want key=%0d total=%0d empty=%0b last=%0b sat=%0b",
                                     $realtime, want.out_key, want.total, want.empty_res,
                                     want.last, want.saturated);
                            $display("%0t: got  key=%0d total=%0d empty=%0b last=%0b sat=%0b",
                                     $realtime, got.out_key, got.total, got.empty_res,
                                     got.last, got.saturated);
                        end
                    end
                end
            end
            // one long hold-off so the result register backs up into the input
            if (!long_hold_done && results_seen >= 20) begin
                long_hold_done = 1'b1;
                recv_hold      = LONG_HOLD;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                rdy = 1'b0;
            end else if (recv_burst > 0) begin
                recv_burst--;
                rdy = 1'b1;
            end else begin
                if ($urandom_range(0, 59) == 0) recv_burst = $urandom_range(40, 120);
                if ($urandom_range(0, 99) < 55) begin
                    rdy = 1'b1;
                end else begin
                    rdy       = 1'b0;
                    recv_hold = draw_gap();
                end
            end
            m_tready <= rdy;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL keyed_weight_sum_table_core");
                $finish;
            end
        end
    end

    initial begin : run_test
        int unsigned sat_key;
        int unsigned rand_items;
        int unsigned sel;
        int unsigned base;
        int unsigned n_add;
        int unsigned n_pop;

        for (int k = 0; k < DEF_KEY_COUNT; k++) begin
            key_total[k]   = 0;
            key_sat[k]     = 1'b0;
            key_present[k] = 1'b0;
        end
        present_keys = 0;

        // directed: empty pop, zero weight, key and weight extremes, ordering
        pop_cmd();
        add_cmd(10'd0, 10'd0);
        add_cmd(10'd1023, 10'd1023);
        add_cmd(10'd1023, 10'd1);
        add_cmd(10'd512, 10'h155);
        add_cmd(10'd512, 10'h2AA);
        pop_cmd();
        pop_cmd();
        pop_cmd();
        pop_cmd();
        add_cmd(10'h2AA, 10'h155);
        add_cmd(10'h155, 10'h2AA);
        pop_cmd();
        pop_cmd();
        pop_cmd();
        // single key pops with last, then restarts from zero
        add_cmd(10'd5, 10'd7);
        pop_cmd();
        add_cmd(10'd5, 10'd3);
        pop_cmd();
        drain_mark();

        // saturation: 1023 * 1024 + 1022 sits one below the ceiling
        sat_key = $urandom_range(0, DEF_KEY_COUNT - 1);
        repeat (1024) add_cmd(KEY_BITS'(sat_key), 10'd1023);
        add_cmd(KEY_BITS'(sat_key), 10'd1022);   // one below the ceiling
        add_cmd(KEY_BITS'(sat_key), 10'd1);      // hits it exactly
        add_cmd(KEY_BITS'(sat_key), 10'd300);    // stays pinned
        pop_cmd();
        pop_cmd();

        // random: mostly fill-then-drain batches over a narrow key window
        rand_items = 0;
        while (rand_items < 120) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                base  = $urandom_range(0, DEF_KEY_COUNT - 1);
                n_add = $urandom_range(1, 16);
                n_pop = $urandom_range(1, n_add + 2);
                repeat (n_add) add_cmd(pick_key(base), pick_weight());
                repeat (n_pop) pop_cmd();
                rand_items += n_add + n_pop;
            end else if (sel < 95) begin
                if ($urandom_range(0, 1)) add_cmd(KEY_BITS'($urandom), pick_weight());
                else pop_cmd();
                rand_items++;
            end else begin
                drain_mark();
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_queue.size() != 0 || s_tvalid || expected_pops.size() != 0)
            @(negedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0 && expected_pops.size() == 0) begin
            $display("PASS keyed_weight_sum_table_core");
        end else begin
            $display("FAIL keyed_weight_sum_table_core");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/kwst_pkg.sv
rtl/kwst_ram.sv
rtl/kwst_ffs.sv
rtl/keyed_weight_sum_table_core.sv
sim/testbench.sv
